@@ design/topological_sort_engine_unit_assert.svh @@
// Assertion macros for the topological sort engine.
`ifndef TOPOLOGICAL_SORT_ENGINE_UNIT_ASSERT_SVH
`define TOPOLOGICAL_SORT_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TSE_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define TSE_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define TSE_ASSERT_IMPLIES(label, clk, rst, a, b)
`define TSE_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ design/tse_pkg.sv @@
`timescale 1ns / 1ps
package tse_pkg;

  localparam logic [1:0] CMD_ADD_NODE = 2'd0;
  localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
  localparam logic [1:0] CMD_SORT     = 2'd2;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int IDW = 6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_RD, S_CHK_EV,
    S_CLR,
    S_CNT_RD, S_CNT_DG, S_CNT_WR,
    S_SEED_RD, S_SEED_EV,
    S_POP, S_POP_EV,
    S_SCAN_RD, S_SCAN_EV, S_SCAN_DG,
    S_DONE, S_FAIL,
    S_EM_RD, S_EM_EV
  } state_t;

endpackage

@@ design/tse_cmd_if.sv @@
`timescale 1ns / 1ps
interface tse_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] source_node;
  logic [5:0] target_node;

  modport source (output valid, command, source_node, target_node, input ready);
  modport sink (input valid, command, source_node, target_node, output ready);
endinterface

@@ design/tse_res_if.sv @@
`timescale 1ns / 1ps
interface tse_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] node_id;
  logic       last;

  modport source (output valid, status, node_id, last, input ready);
  modport sink (input valid, status, node_id, last, output ready);
endinterface

@@ design/topological_sort_engine_unit.sv @@
`timescale 1ns / 1ps
// Add edge: written to the edge table with no result beat, or a full result beat when the table is full.
// Add node: result beat the cycle after acceptance; the next command waits until that beat is taken.
// Sort: check, clear, count, seed, then pop and scan, then emit, plus output stalls;
// the edge table read port sets the pace.
// One command is taken at a time; ready is low during a sort or while a result waits.
// Reset (rst, synchronous) empties the node and edge counts; tables need no clearing.
`include "topological_sort_engine_unit_assert.svh"
module topological_sort_engine_unit #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic        clk,
  input  logic        rst,
  tse_cmd_if.sink     cmd,
  tse_res_if.source   res
);

  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int NAW  = $clog2(MAX_NODES);
  localparam int EAW  = $clog2(MAX_EDGES);
  localparam int DW   = $clog2(MAX_EDGES + 1);
  localparam int CMPW = (NCW > tse_pkg::IDW) ? NCW : tse_pkg::IDW;
  localparam int IDW  = tse_pkg::IDW;

  // Control state
  tse_pkg::state_t state, state_next;
  logic [NCW-1:0] nodes, nodes_next;
  logic [ECW-1:0] edges, edges_next;
  logic [ECW-1:0] ecnt, ecnt_next;
  logic [NCW-1:0] ncnt, ncnt_next;
  logic [NCW-1:0] depth, depth_next;
  logic [NCW-1:0] slen, slen_next;
  logic [IDW-1:0] cur, cur_next;

  // Output register
  logic           ov, ov_next;
  logic [1:0]     o_status, o_status_next;
  logic [IDW-1:0] o_id, o_id_next;
  logic           o_last, o_last_next;

  // Memories
  logic [2*IDW-1:0] edge_mem [MAX_EDGES];
  logic [DW-1:0]    deg_mem  [MAX_NODES];
  logic [IDW-1:0]   stk_mem  [MAX_NODES];
  logic [IDW-1:0]   srt_mem  [MAX_NODES];

  logic [2*IDW-1:0] e_rd;
  logic [DW-1:0]    deg_rd;
  logic [IDW-1:0]   stk_rd;
  logic [IDW-1:0]   srt_rd;

  logic           edge_we;
  logic           deg_we;
  logic [NAW-1:0] deg_waddr, deg_raddr;
  logic [DW-1:0]  deg_wdata;
  logic           stk_we;
  logic [IDW-1:0] stk_wdata;
  logic           srt_we;
  logic [NAW-1:0] stk_raddr;

  logic           in_fire;
  logic [IDW-1:0] e_src, e_tgt;

  assign in_fire   = cmd.valid && cmd.ready;
  assign e_src     = e_rd[2*IDW-1:IDW];
  assign e_tgt     = e_rd[IDW-1:0];
  assign stk_raddr = NAW'(depth - NCW'(1));

  assign res.valid   = ov;
  assign res.status  = o_status;
  assign res.node_id = o_id;
  assign res.last    = o_last;

  // Edge table: write on add edge, read every cycle at the scan index
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edges[EAW-1:0]] <= {cmd.source_node, cmd.target_node};
    end
    e_rd <= edge_mem[ecnt[EAW-1:0]];
  end

  // In-degree store
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd <= deg_mem[deg_raddr];
  end

  // Ready stack: push at depth, read the top entry (depth minus one) every cycle
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth[NAW-1:0]] <= stk_wdata;
    end
    stk_rd <= stk_mem[stk_raddr];
  end

  // Sorted order: append at slen, read at the emit index
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[slen[NAW-1:0]] <= cur_next;
    end
    srt_rd <= srt_mem[ncnt[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tse_pkg::S_IDLE;
      nodes <= '0;
      edges <= '0;
      ecnt  <= '0;
      ncnt  <= '0;
      depth <= '0;
      slen  <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      nodes <= nodes_next;
      edges <= edges_next;
      ecnt  <= ecnt_next;
      ncnt  <= ncnt_next;
      depth <= depth_next;
      slen  <= slen_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    o_status <= o_status_next;
    o_id     <= o_id_next;
    o_last   <= o_last_next;
  end

  // Sequencer: one edge or one node per step through the shared table ports
  always_comb begin
    state_next    = state;
    nodes_next    = nodes;
    edges_next    = edges;
    ecnt_next     = ecnt;
    ncnt_next     = ncnt;
    depth_next    = depth;
    slen_next     = slen;
    cur_next      = cur;
    ov_next       = ov && !res.ready;
    o_status_next = o_status;
    o_id_next     = o_id;
    o_last_next   = o_last;
    cmd.ready     = 1'b0;
    edge_we       = 1'b0;
    deg_we        = 1'b0;
    deg_waddr     = NAW'(e_tgt);
    deg_wdata     = '0;
    deg_raddr     = NAW'(e_tgt);
    stk_we        = 1'b0;
    stk_wdata     = e_tgt;
    srt_we        = 1'b0;

    case (state)
      tse_pkg::S_IDLE: begin
        cmd.ready = !ov;
        if (in_fire) begin
          case (cmd.command)
            tse_pkg::CMD_ADD_NODE: begin
              ov_next     = 1'b1;
              o_last_next = 1'b1;
              if (nodes == NCW'(MAX_NODES)) begin
                o_status_next = tse_pkg::ST_FULL;
                o_id_next     = '0;
              end else begin
                o_status_next = tse_pkg::ST_ADDED;
                o_id_next     = IDW'(nodes);
                nodes_next    = nodes + NCW'(1);
              end
            end
            tse_pkg::CMD_ADD_EDGE: begin
              if (edges == ECW'(MAX_EDGES)) begin
                ov_next       = 1'b1;
                o_last_next   = 1'b1;
                o_status_next = tse_pkg::ST_FULL;
                o_id_next     = '0;
              end else begin
                edge_we    = 1'b1;
                edges_next = edges + ECW'(1);
              end
            end
            tse_pkg::CMD_SORT: begin
              ecnt_next  = '0;
              state_next = tse_pkg::S_CHK_RD;
            end
            default: begin
            end
          endcase
        end
      end
      // Check that every edge names a node in use
      tse_pkg::S_CHK_RD: begin
        if (ecnt == edges) begin
          ncnt_next  = '0;
          state_next = tse_pkg::S_CLR;
        end else begin
          state_next = tse_pkg::S_CHK_EV;
        end
      end
      tse_pkg::S_CHK_EV: begin
        if (CMPW'(e_src) >= CMPW'(nodes) || CMPW'(e_tgt) >= CMPW'(nodes)) begin
          state_next = tse_pkg::S_FAIL;
        end else begin
          ecnt_next  = ecnt + ECW'(1);
          state_next = tse_pkg::S_CHK_RD;
        end
      end
      tse_pkg::S_CLR: begin
        if (ncnt == nodes) begin
          ecnt_next  = '0;
          state_next = tse_pkg::S_CNT_RD;
        end else begin
          deg_we    = 1'b1;
          deg_waddr = ncnt[NAW-1:0];
          deg_wdata = '0;
          ncnt_next = ncnt + NCW'(1);
        end
      end
      // Count in-degrees: read edge, read degree, write degree plus one
      tse_pkg::S_CNT_RD: begin
        if (ecnt == edges) begin
          ncnt_next  = '0;
          depth_next = '0;
          state_next = tse_pkg::S_SEED_RD;
        end else begin
          state_next = tse_pkg::S_CNT_DG;
        end
      end
      tse_pkg::S_CNT_DG: begin
        state_next = tse_pkg::S_CNT_WR;
      end
      tse_pkg::S_CNT_WR: begin
        deg_we     = 1'b1;
        deg_wdata  = DW'(deg_rd + DW'(1));
        ecnt_next  = ecnt + ECW'(1);
        state_next = tse_pkg::S_CNT_RD;
      end
      // Seed the stack with zero in-degree nodes, ascending
      tse_pkg::S_SEED_RD: begin
        deg_raddr = ncnt[NAW-1:0];
        if (ncnt == nodes) begin
          slen_next  = '0;
          state_next = tse_pkg::S_POP;
        end else begin
          state_next = tse_pkg::S_SEED_EV;
        end
      end
      tse_pkg::S_SEED_EV: begin
        if (deg_rd == '0) begin
          stk_we     = 1'b1;
          stk_wdata  = IDW'(ncnt);
          depth_next = depth + NCW'(1);
        end
        ncnt_next  = ncnt + NCW'(1);
        state_next = tse_pkg::S_SEED_RD;
      end
      tse_pkg::S_POP: begin
        if (depth == '0) begin
          state_next = tse_pkg::S_DONE;
        end else begin
          depth_next = depth - NCW'(1);
          state_next = tse_pkg::S_POP_EV;
        end
      end
      tse_pkg::S_POP_EV: begin
        cur_next   = stk_rd;
        srt_we     = 1'b1;
        slen_next  = slen + NCW'(1);
        ecnt_next  = '0;
        state_next = tse_pkg::S_SCAN_RD;
      end
      // Release the targets of the popped node
      tse_pkg::S_SCAN_RD: begin
        if (ecnt == edges) begin
          state_next = tse_pkg::S_POP;
        end else begin
          state_next = tse_pkg::S_SCAN_EV;
        end
      end
      tse_pkg::S_SCAN_EV: begin
        if (e_src == cur) begin
          state_next = tse_pkg::S_SCAN_DG;
        end else begin
          ecnt_next  = ecnt + ECW'(1);
          state_next = tse_pkg::S_SCAN_RD;
        end
      end
      tse_pkg::S_SCAN_DG: begin
        if (deg_rd != '0) begin
          deg_we    = 1'b1;
          deg_wdata = DW'(deg_rd - DW'(1));
          if (deg_rd == DW'(1)) begin
            stk_we     = 1'b1;
            depth_next = depth + NCW'(1);
          end
        end
        ecnt_next  = ecnt + ECW'(1);
        state_next = tse_pkg::S_SCAN_RD;
      end
      tse_pkg::S_DONE: begin
        if (slen != nodes) begin
          state_next = tse_pkg::S_FAIL;
        end else if (slen == '0) begin
          state_next = tse_pkg::S_IDLE;
        end else begin
          ncnt_next  = '0;
          state_next = tse_pkg::S_EM_RD;
        end
      end
      tse_pkg::S_FAIL: begin
        if (!ov) begin
          ov_next       = 1'b1;
          o_status_next = tse_pkg::ST_FAIL;
          o_id_next     = '0;
          o_last_next   = 1'b1;
          state_next    = tse_pkg::S_IDLE;
        end
      end
      // Emit one order beat per node; hold until the output register is free
      tse_pkg::S_EM_RD: begin
        if (!ov) begin
          state_next = tse_pkg::S_EM_EV;
        end
      end
      tse_pkg::S_EM_EV: begin
        ov_next       = 1'b1;
        o_status_next = tse_pkg::ST_ORDER;
        o_id_next     = srt_rd;
        o_last_next   = (ncnt + NCW'(1)) == slen;
        ncnt_next     = ncnt + NCW'(1);
        state_next    = ((ncnt + NCW'(1)) == slen) ? tse_pkg::S_IDLE : tse_pkg::S_EM_RD;
      end
      default: begin
        state_next = tse_pkg::S_IDLE;
      end
    endcase
  end

  `TSE_ASSERT_IMPLIES(a_ready_idle, clk, rst, cmd.ready, state == tse_pkg::S_IDLE && !ov)
  `TSE_ASSERT_IMPLIES(a_depth_bound, clk, rst, 1'b1, depth <= nodes)
  `TSE_ASSERT_IMPLIES(a_slen_bound, clk, rst, 1'b1, slen <= nodes)
  `TSE_ASSERT_NEXT(a_emit_last, clk, rst, state == tse_pkg::S_EM_EV && (ncnt + NCW'(1)) == slen, state == tse_pkg::S_IDLE && ov && o_last)

endmodule
